FILE: src/pscr_pkg.sv
// shared types and constants of the parabolic s-curve ramp unit
// no dependencies; imported by the alu, the core, the top level and the bench
package pscr_pkg;

  localparam int unsigned CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_START_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DURATION     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_TIME   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_INTERVAL = 3'd4;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_SQT,
    C_SQX,
    C_MAG,
    C_DIV,
    C_DONE
  } core_state_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_EVAL,
    TOP_CALC,
    TOP_PUT
  } top_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

FILE: src/pscr_alu.sv
// shared wide add/subtract unit of the ramp core
// depends on pscr_pkg for the operation codes
module pscr_alu import pscr_pkg::*; #(
  parameter int unsigned W = 82
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  alu_op_e      op_i,
  output logic [W-1:0] res_o,
  output logic         cy_o
);

  logic [W:0] full;

  always_comb begin
    case (op_i)
      ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      default: full = {1'b0, a_i} + {1'b0, b_i};
    endcase
  end

  assign res_o = full[W-1:0];
  assign cy_o  = full[W];

endmodule

FILE: src/pscr_core.sv
// sequencer for round(2*mag*x^2 / t^2): shift-add squares and product, restoring divide
// depends on pscr_pkg and pscr_alu
module pscr_core import pscr_pkg::*; #(
  parameter int unsigned TB = 32,
  parameter int unsigned LB = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [TB-1:0] x_i,
  input  logic [TB-1:0] t_i,
  input  logic [LB-1:0] mag_i,
  output core_stat_t    stat_o,
  output logic [LB-1:0] q_o
);

  localparam int unsigned W    = 2 * TB + LB + 2;
  localparam int unsigned MPW  = (TB > LB) ? TB : LB;
  localparam int unsigned QW   = LB + 2;
  localparam int unsigned CMAX = (TB > QW) ? TB : QW;
  localparam int unsigned CW   = (CMAX > 1) ? $clog2(CMAX) : 1;

  core_state_e state_q, state_d;

  logic [W-1:0]    acc_q, mc_q;
  logic [MPW-1:0]  mp_q;
  logic [CW-1:0]   cnt_q;
  logic [TB-1:0]   xs_q;
  logic [LB-1:0]   mag_q;
  logic [2*TB-1:0] den_q;
  logic [QW-1:0]   qt_q;
  logic [LB-1:0]   q_q;

  alu_op_e      alu_op;
  logic [W-1:0] alu_b, alu_res;
  logic         alu_cy, alu_ge, last;
  logic [QW-1:0] qt_nx;
  logic [QW:0]   qinc;

  pscr_alu #(.W(W)) u_alu (
    .a_i  (acc_q),
    .b_i  (alu_b),
    .op_i (alu_op),
    .res_o(alu_res),
    .cy_o (alu_cy)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE:  if (start_i) state_d = C_SQT;
      C_SQT:   if (last) state_d = C_SQX;
      C_SQX:   if (last) state_d = C_MAG;
      C_MAG:   if (last) state_d = C_DIV;
      C_DIV:   if (last) state_d = C_DONE;
      C_DONE:  state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_comb begin
    alu_op = ALU_ADD;
    alu_b  = '0;
    case (state_q)
      C_DIV: begin
        alu_op = ALU_SUB;
        alu_b  = mc_q;
      end
      C_SQT, C_SQX, C_MAG: begin
        alu_op = ALU_ADD;
        alu_b  = mp_q[0] ? mc_q : '0;
      end
      default: begin
        alu_op = ALU_ADD;
        alu_b  = '0;
      end
    endcase
  end

  assign last   = (cnt_q == '0);
  assign alu_ge = !alu_cy;
  assign qt_nx  = {qt_q[QW-2:0], alu_ge};
  assign qinc   = {1'b0, qt_nx} + {{QW{1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          acc_q <= '0;
          mc_q  <= W'(t_i);
          mp_q  <= MPW'(t_i);
          cnt_q <= CW'(TB - 1);
          xs_q  <= x_i;
          mag_q <= mag_i;
        end
      end
      C_SQT: begin
        if (last) begin
          den_q <= alu_res[2*TB-1:0];
          acc_q <= '0;
          mc_q  <= W'(xs_q);
          mp_q  <= MPW'(xs_q);
          cnt_q <= CW'(TB - 1);
        end else begin
          acc_q <= alu_res;
          mc_q  <= mc_q << 1;
          mp_q  <= mp_q >> 1;
          cnt_q <= cnt_q - 1'b1;
        end
      end
      C_SQX: begin
        if (last) begin
          acc_q <= '0;
          mc_q  <= alu_res << 2;
          mp_q  <= MPW'(mag_q);
          cnt_q <= CW'(LB - 1);
        end else begin
          acc_q <= alu_res;
          mc_q  <= mc_q << 1;
          mp_q  <= mp_q >> 1;
          cnt_q <= cnt_q - 1'b1;
        end
      end
      C_MAG: begin
        if (last) begin
          acc_q <= alu_res;
          mc_q  <= W'(den_q) << (LB + 1);
          qt_q  <= '0;
          cnt_q <= CW'(QW - 1);
        end else begin
          acc_q <= alu_res;
          mc_q  <= mc_q << 1;
          mp_q  <= mp_q >> 1;
          cnt_q <= cnt_q - 1'b1;
        end
      end
      C_DIV: begin
        if (alu_ge) acc_q <= alu_res;
        qt_q  <= qt_nx;
        mc_q  <= mc_q >> 1;
        cnt_q <= cnt_q - 1'b1;
        if (last) q_q <= qinc[LB:1];
      end
      default: begin
      end
    endcase
  end

  assign stat_o.busy = (state_q != C_IDLE);
  assign stat_o.done = (state_q == C_DONE);
  assign q_o         = q_q;

endmodule

FILE: src/parabolic_s_curve_ramp_unit.sv
// top level of the parabolic s-curve ramp unit: registers, throttle, output register
// depends on pscr_pkg and pscr_core
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_stall_o   in_current_time_i
//  out      output     out_valid_o/out_stall_i out_level_o, out_updated_o, out_active_o
//  cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// a word that computes a new ramp point passes through the bit-serial squares, product
// and divide on one adder; degenerate, throttled and past-end words skip the core
// and go from evaluation straight to the output register
// reset clears the registers to zero and the ramp state to running, no update done
// the input stalls from acceptance until the word sits in the output register
module parabolic_s_curve_ramp_unit import pscr_pkg::*; #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned LEVEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [((TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS)-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [TIME_BITS-1:0]         in_current_time_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [LEVEL_BITS-1:0] out_level_o,
  output logic                         out_updated_o,
  output logic                         out_active_o
);

  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned LB = LEVEL_BITS;

  top_state_e state_q, state_d;

  logic signed [LB-1:0] start_q, stop_q;
  logic [TB-1:0] dur_q, st_q, intv_q;
  logic [TB-1:0] last_q;
  logic          any_q, run_q;
  logic [TB-1:0] now_q;

  logic [LB-1:0] pend_lvl_q;
  logic          pend_upd_q, pend_act_q, use_q_q, half_q, neg_q;

  logic                 out_valid_q, out_upd_q, out_act_q;
  logic signed [LB-1:0] out_level_q;

  logic [TB:0]   diff_l, diff_e;
  logic [TB-1:0] e, x;
  logic          degen, throttle, past, first, core_start, out_free, add;
  logic signed [LB:0] dlt, mag_w, base_x, q_x, lvl_x;
  logic [LB-1:0] mag;
  logic [LB-1:0] core_q;
  core_stat_t    core_stat;

  // word evaluation
  assign diff_l   = {1'b0, now_q} - {1'b0, last_q};
  assign throttle = (intv_q != '0) && any_q && (diff_l[TB] || (diff_l[TB-1:0] < intv_q));
  assign diff_e   = {1'b0, now_q} - {1'b0, st_q};
  assign e        = diff_e[TB] ? '0 : diff_e[TB-1:0];
  assign past     = (e >= dur_q);
  assign first    = ({e, 1'b0} < {1'b0, dur_q});
  assign x        = first ? e : (dur_q - e);
  assign degen    = (start_q == stop_q) || (dur_q == '0);
  assign dlt      = (LB+1)'(stop_q) - (LB+1)'(start_q);
  assign mag_w    = dlt[LB] ? -dlt : dlt;
  assign mag      = mag_w[LB-1:0];

  // final level
  assign add    = half_q ^ neg_q;
  assign base_x = half_q ? (LB+1)'(start_q) : (LB+1)'(stop_q);
  assign q_x    = signed'({1'b0, core_q});
  assign lvl_x  = add ? (base_x + q_x) : (base_x - q_x);

  assign out_free = !out_valid_q || !out_stall_i;

  pscr_core #(.TB(TB), .LB(LB)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(core_start),
    .x_i    (x),
    .t_i    (dur_q),
    .mag_i  (mag),
    .stat_o (core_stat),
    .q_o    (core_q)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      TOP_IDLE: if (in_valid_i) state_d = TOP_EVAL;
      TOP_EVAL: state_d = core_start ? TOP_CALC : TOP_PUT;
      TOP_CALC: if (core_stat.done) state_d = TOP_PUT;
      TOP_PUT:  if (out_free) state_d = TOP_IDLE;
      default:  state_d = TOP_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != TOP_IDLE);
    core_start = (state_q == TOP_EVAL) && !degen && !throttle && !past;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TOP_IDLE;
      start_q <= '0;
      stop_q  <= '0;
      dur_q   <= '0;
      st_q    <= '0;
      intv_q  <= '0;
      last_q  <= '0;
      any_q   <= 1'b0;
      run_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_LEVEL:  start_q <= cfg_data_i[LB-1:0];
          CFG_STOP_LEVEL:   stop_q  <= cfg_data_i[LB-1:0];
          CFG_DURATION:     dur_q   <= cfg_data_i[TB-1:0];
          CFG_START_TIME:   st_q    <= cfg_data_i[TB-1:0];
          CFG_MIN_INTERVAL: intv_q  <= cfg_data_i[TB-1:0];
          default: begin
          end
        endcase
      end
      if (state_q == TOP_EVAL && !degen && !throttle) begin
        last_q <= now_q;
        any_q  <= 1'b1;
        run_q  <= !past;
      end
      if (state_q == TOP_PUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == TOP_IDLE && in_valid_i) now_q <= in_current_time_i;
    if (state_q == TOP_EVAL) begin
      use_q_q <= 1'b0;
      half_q  <= first;
      neg_q   <= dlt[LB];
      if (degen) begin
        pend_lvl_q <= '0;
        pend_upd_q <= 1'b0;
        pend_act_q <= 1'b0;
      end else if (throttle) begin
        pend_lvl_q <= '0;
        pend_upd_q <= 1'b0;
        pend_act_q <= run_q;
      end else begin
        pend_lvl_q <= stop_q;
        pend_upd_q <= 1'b1;
        pend_act_q <= !past;
        use_q_q    <= !past;
      end
    end
    if (state_q == TOP_PUT && out_free) begin
      out_level_q <= use_q_q ? lvl_x[LB-1:0] : pend_lvl_q;
      out_upd_q   <= pend_upd_q;
      out_act_q   <= pend_act_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_level_o   = out_level_q;
  assign out_updated_o = out_upd_q;
  assign out_active_o  = out_act_q;

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.busy |-> in_stall_o)
    else $error("core busy while input not stalled");

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.done |-> (state_q == TOP_CALC))
    else $error("core finished outside calc state");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == TOP_EVAL))
    else $error("accepted word not evaluated");

  a_quiet_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_updated_o) |-> (out_level_o == '0))
    else $error("level nonzero on word without update");

endmodule

FILE: bench/tb.sv
// self-checking bench for parabolic_s_curve_ramp_unit: directed corner ticks, then random ramps
// depends on pscr_pkg and the ramp unit rtl; predicts each output word at input acceptance
module tb import pscr_pkg::*;;

  localparam int unsigned TIMEOUT_CYCLES = 600000;

  typedef struct {
    logic [15:0] level;
    logic        updated;
    logic        active;
  } level_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = CFG_START_LEVEL;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [31:0]        in_current_time_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] out_level_o;
  logic               out_updated_o;
  logic               out_active_o;

  parabolic_s_curve_ramp_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_current_time_i (in_current_time_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_level_o       (out_level_o),
    .out_updated_o     (out_updated_o),
    .out_active_o      (out_active_o)
  );

  always #5 clk_i = ~clk_i;

  // register copies and ramp state of the predictor
  logic signed [15:0] set_start = '0;
  logic signed [15:0] set_stop = '0;
  logic [31:0]        set_dur = '0;
  logic [31:0]        set_t0 = '0;
  logic [31:0]        set_gap = '0;
  logic [31:0]        last_upd = '0;
  logic               upd_seen = 1'b0;
  logic               running = 1'b1;

  logic [31:0]  pending_times[$];
  level_word_t  expected_words[$];
  level_word_t  want;
  int           errors = 0;
  int           n_results = 0;
  int           n_updates = 0;
  int           n_ticks = 0;
  int           n_settings = 0;
  int unsigned  cycles = 0;
  int           tx_gap = 0;
  int           rx_hold = 0;
  logic         long_hold_done = 1'b0;
  logic         steady = 1'b0;

  function automatic int para_mag(input int mag, input logic [31:0] x, input logic [31:0] t);
    logic [127:0] num, den, q, r;
    num = 128'(mag) * 128'(x) * 128'(x) * 128'd2;
    den = 128'(t) * 128'(t);
    q = num / den;
    r = num % den;
    if ((r << 1) >= den) q = q + 1;
    return int'(q);
  endfunction

  function automatic level_word_t next_ramp_word(input logic [31:0] now);
    level_word_t w;
    logic [31:0] e;
    int d, sgn, lvl;
    w.level = '0;
    w.updated = 1'b0;
    w.active = 1'b0;
    if (set_start == set_stop || set_dur == 0) return w;
    if (set_gap != 0 && upd_seen && (now < last_upd || now - last_upd < set_gap)) begin
      w.active = running;
      return w;
    end
    last_upd = now;
    upd_seen = 1'b1;
    running = 1'b1;
    e = (now > set_t0) ? now - set_t0 : '0;
    d = int'(set_stop) - int'(set_start);
    sgn = (d < 0) ? -1 : 1;
    if (e >= set_dur) begin
      lvl = int'(set_stop);
      running = 1'b0;
    end else if ({e, 1'b0} < {1'b0, set_dur}) begin
      lvl = int'(set_start) + sgn * para_mag(d * sgn, e, set_dur);
    end else begin
      lvl = int'(set_stop) - sgn * para_mag(d * sgn, set_dur - e, set_dur);
    end
    w.level = 16'(lvl);
    w.updated = 1'b1;
    w.active = running;
    return w;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START_LEVEL:  set_start = data[15:0];
      CFG_STOP_LEVEL:   set_stop = data[15:0];
      CFG_DURATION:     set_dur = data;
      CFG_START_TIME:   set_t0 = data;
      CFG_MIN_INTERVAL: set_gap = data;
      default: ;
    endcase
  endtask

  task automatic load_ramp(input logic [15:0] s, input logic [15:0] p, input logic [31:0] dur,
                           input logic [31:0] t0, input logic [31:0] gap);
    write_reg(CFG_START_LEVEL, {16'($urandom), s});
    write_reg(CFG_STOP_LEVEL, {16'($urandom), p});
    write_reg(CFG_DURATION, dur);
    write_reg(CFG_START_TIME, t0);
    write_reg(CFG_MIN_INTERVAL, gap);
    n_settings++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_times.size() != 0 || in_valid_i || expected_words.size() != 0);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_words.push_back(next_ramp_word(in_current_time_i));
        n_ticks++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap != 0) begin
          in_valid_i <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (pending_times.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!steady && $urandom_range(0, 7) == 0) begin
          in_valid_i <= 1'b0;
          tx_gap <= $urandom_range(0, 4);
        end else begin
          in_valid_i <= 1'b1;
          in_current_time_i <= pending_times.pop_front();
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (out_updated_o) n_updates++;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: word with nothing expected: level %0d updated %0b active %0b",
                   $time, out_level_o, out_updated_o, out_active_o);
        end else begin
          want = expected_words.pop_front();
          if (want.level !== out_level_o) begin
            errors++;
            $display("%0t: level expected %0d got %0d", $time, $signed(want.level), out_level_o);
          end
          if (want.updated !== out_updated_o) begin
            errors++;
            $display("%0t: updated expected %0b got %0b", $time, want.updated, out_updated_o);
          end
          if (want.active !== out_active_o) begin
            errors++;
            $display("%0t: active expected %0b got %0b", $time, want.active, out_active_o);
          end
        end
      end
      if (rx_hold != 0) begin
        out_stall_i <= 1'b1;
        rx_hold <= rx_hold - 1;
      end else if (!long_hold_done && n_results >= 150) begin
        // long hold so the output register fills and the input backs up
        out_stall_i <= 1'b1;
        rx_hold <= 399;
        long_hold_done <= 1'b1;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        rx_hold <= $urandom_range(0, 4);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == TIMEOUT_CYCLES) begin
      $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [15:0] s_lvl, p_lvl;
    logic [31:0] dur, t0, gap, cursor, step_max;
    int n_random, n_items, r;
    n_random = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers still at reset: degenerate ramp
    pending_times.push_back(32'h0000_0000);
    pending_times.push_back(32'hffff_ffff);
    wait_drained();

    // full swing, clamp before start, both halves, half-way, end and past end
    load_ramp(16'h8000, 16'h7fff, 32'd100, 32'd1000, 32'd0);
    pending_times.push_back(32'd0);
    pending_times.push_back(32'd1000);
    pending_times.push_back(32'd1025);
    pending_times.push_back(32'd1049);
    pending_times.push_back(32'd1050);
    pending_times.push_back(32'd1075);
    pending_times.push_back(32'd1099);
    pending_times.push_back(32'd1100);
    pending_times.push_back(32'hffff_ffff);
    wait_drained();

    // falling ramp with exact half rounding ties
    load_ramp(16'd0, 16'hfffc, 32'd4, 32'd0, 32'd0);
    for (int k = 1; k <= 4; k++) pending_times.push_back(32'(k));
    wait_drained();

    // widest interval throttles everything after the last update
    load_ramp(16'h7fff, 16'h8000, 32'hffff_ffff, 32'd0, 32'hffff_ffff);
    pending_times.push_back(32'd5);
    pending_times.push_back(32'hffff_ffff);
    wait_drained();

    // short interval, time going backwards
    load_ramp(16'h7fff, 16'h8000, 32'hffff_ffff, 32'd0, 32'd3);
    pending_times.push_back(32'd7);
    pending_times.push_back(32'd8);
    pending_times.push_back(32'd2);
    pending_times.push_back(32'd10);
    wait_drained();

    // equal levels are degenerate too
    load_ramp(16'd123, 16'd123, 32'd10, 32'd0, 32'd0);
    pending_times.push_back(32'd3);
    wait_drained();

    while (n_random < 850) begin
      if (n_random >= 720) steady = 1'b1;
      r = $urandom_range(0, 9);
      s_lvl = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7fff : 16'($urandom);
      r = $urandom_range(0, 9);
      p_lvl = (r == 0) ? s_lvl : (r == 1) ? 16'h8000 : (r == 2) ? 16'h7fff : 16'($urandom);
      r = $urandom_range(0, 19);
      if (r == 0) dur = '0;
      else if (r <= 2) dur = $urandom;
      else if (r <= 4) dur = $urandom_range(1, 4);
      else dur = $urandom_range(5, 3000);
      r = $urandom_range(0, 9);
      if (r < 6) gap = '0;
      else if (r < 9) gap = $urandom_range(1, dur / 8 + 1);
      else gap = $urandom;
      t0 = $urandom;
      load_ramp(s_lvl, p_lvl, dur, t0, gap);
      n_items = $urandom_range(20, 80);
      step_max = dur / 32'(n_items) * 2 + 1;
      cursor = t0 - $urandom_range(0, 20);
      for (int k = 0; k < n_items; k++) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          pending_times.push_back($urandom);
        end else if (r == 1) begin
          pending_times.push_back(cursor - $urandom_range(1, 50));
        end else begin
          pending_times.push_back(cursor);
          cursor = cursor + $urandom_range(0, step_max);
        end
      end
      n_random += n_items;
      wait_drained();
    end

    repeat (120) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
    end
    $display("ran %0d ticks across %0d ramp settings: %0d level updates, %0d held words",
             n_ticks, n_settings, n_updates, n_results - n_updates);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/pscr_pkg.sv
src/pscr_alu.sv
src/pscr_core.sv
src/parabolic_s_curve_ramp_unit.sv
bench/tb.sv
